### rtl/core/pulse_period_tachometer_unit_macros.svh
// Assertion macros shared by the tachometer RTL.
`ifndef PULSE_PERIOD_TACHOMETER_UNIT_MACROS_SVH
`define PULSE_PERIOD_TACHOMETER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at the rising clock edge outside reset.
`define PPT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed in tachometer logic");
// Next-cycle implication, checked at the rising clock edge outside reset.
`define PPT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed in tachometer logic");
`else
`define PPT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PPT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/ppt_pkg.sv
// Package with the types, codes and constants of the tachometer.
package ppt_pkg;

    // Field and register widths.
    localparam int TS_W       = 32;
    localparam int GLITCH_W   = 16;
    localparam int PERIOD_W   = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int RPM_W      = 26;
    localparam int DIV_W      = PERIOD_W + 1;
    localparam int CNT_W      = $clog2(RPM_W);
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;

    // Kind of an input item, carried in tuser.
    localparam logic OP_EDGE   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [GLITCH_W-1:0] GLITCH_RESET     = 16'd500;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 20'd1000;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = 20'd100000;

    // Microseconds per minute: the dividend of the speed calculation.
    localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One report job handed from the front end to the divider.
    typedef struct packed {
        logic                in_range;
        logic [PERIOD_W-1:0] period;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_PUBLISH
    } bk_state_t;

endpackage

### rtl/core/pulse_period_tachometer_unit.sv
// Top level of the pulse period tachometer.
//
// The tachometer turns rising pulse edges into a motor speed. Each input item is
// either an edge (tuser low) with a free-running 32-bit microsecond timestamp in
// tdata, or a report request (tuser high, tdata ignored). An edge stores the
// wrap-around gap since the previous edge as the pulse period, or zero when the
// gap is shorter than the glitch limit; the first edge after reset measures from
// time zero. A report returns one item holding rpm = 60000000 / (1 + period) when
// the period lies between the minimum and maximum limits, and zero otherwise.
// Edges produce no result. The front end takes one item every cycle: an edge is
// finished in that cycle, and a report is classified and placed in a small job
// queue. The back end runs a restoring divider that retires one quotient bit a
// cycle; a report in range passes through a start, 26 bit steps and a publish
// step, while a report out of range is answered from the idle state. Edges keep
// flowing during a division; input is held off only while the job queue is full.
// The result sits in an output register, so a stalled result does not block the
// divider from starting on the next job. The limits must be written through the
// configuration port only while the block is idle, which the block does not
// enforce; a write to an index beyond the three registers is ignored.
module pulse_period_tachometer_unit #(
    parameter int QUEUE_DEPTH = ppt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: index 0 glitch_us, 1 min_period_us, 2 max_period_us.
    input  logic                           cfg_wr_en,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppt_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] timestamp_us
    input  logic [0:0]                     s_tuser,   // [0] operation
    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppt_pkg::M_TDATA_W-1:0]  m_tdata    // [25:0] rpm, [31:26] zero
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    ppt_pkg::job_t push_job;
    ppt_pkg::job_t head_job;

    // Front end: holds the limits, times the edges and classifies reports.
    ppt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // Report jobs wait here, in order, until the divider is free.
    ppt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job)
    );

    // Back end: bit-serial division and the output register.
    ppt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/core/ppt_front.sv
// Front end: configuration registers, edge timing and report classification.
module ppt_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ppt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output ppt_pkg::job_t                   q_job
);

    logic [ppt_pkg::GLITCH_W-1:0] glitch_reg;
    logic [ppt_pkg::PERIOD_W-1:0] min_period_reg;
    logic [ppt_pkg::PERIOD_W-1:0] max_period_reg;
    logic [ppt_pkg::TS_W-1:0]     last_edge_reg;
    logic [ppt_pkg::TS_W-1:0]     last_edge_next;
    logic [ppt_pkg::TS_W-1:0]     period_reg;
    logic [ppt_pkg::TS_W-1:0]     period_next;
    logic [ppt_pkg::TS_W-1:0]     gap;
    logic                         accept;
    logic                         is_edge;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_edge  = (s_tuser[0] == ppt_pkg::OP_EDGE);

    // Wrap-around gap since the previous edge; short gaps count as glitches.
    assign gap = s_tdata[ppt_pkg::TS_W-1:0] - last_edge_reg;

    always_comb begin
        last_edge_next = last_edge_reg;
        period_next    = period_reg;
        if (accept && is_edge) begin
            last_edge_next = s_tdata[ppt_pkg::TS_W-1:0];
            period_next    = (gap < ppt_pkg::TS_W'(glitch_reg)) ? '0 : gap;
        end
    end

    assign q_push         = accept && !is_edge;
    assign q_job.in_range = (period_reg >= ppt_pkg::TS_W'(min_period_reg)) &&
                            (period_reg <= ppt_pkg::TS_W'(max_period_reg));
    assign q_job.period   = period_reg[ppt_pkg::PERIOD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glitch_reg     <= ppt_pkg::GLITCH_RESET;
            min_period_reg <= ppt_pkg::MIN_PERIOD_RESET;
            max_period_reg <= ppt_pkg::MAX_PERIOD_RESET;
            last_edge_reg  <= '0;
            period_reg     <= '0;
        end else begin
            last_edge_reg <= last_edge_next;
            period_reg    <= period_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ppt_pkg::CFG_GLITCH:
                        glitch_reg <= cfg_wdata[ppt_pkg::GLITCH_W-1:0];
                    ppt_pkg::CFG_MIN_PERIOD:
                        min_period_reg <= cfg_wdata[ppt_pkg::PERIOD_W-1:0];
                    ppt_pkg::CFG_MAX_PERIOD:
                        max_period_reg <= cfg_wdata[ppt_pkg::PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### rtl/core/ppt_queue.sv
// Short job queue between the front end and the divider.
`include "pulse_period_tachometer_unit_macros.svh"
module ppt_queue #(
    parameter int DEPTH = ppt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ppt_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output ppt_pkg::job_t head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppt_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `PPT_ASSERT_IMP(a_q_no_overflow, aclk, aresetn, push, !full)
    `PPT_ASSERT_IMP(a_q_no_underflow, aclk, aresetn, pop, valid)
    `PPT_ASSERT_IMP(a_q_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

### rtl/core/ppt_back.sv
// Back end: iterative speed division and the registered result stage.
`include "pulse_period_tachometer_unit_macros.svh"
module ppt_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  ppt_pkg::job_t                 q_job,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ppt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DIV_W = ppt_pkg::DIV_W;
    localparam int RPM_W = ppt_pkg::RPM_W;
    localparam int CNT_W = ppt_pkg::CNT_W;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RPM_W - 1);

    ppt_pkg::bk_state_t state_reg;
    ppt_pkg::bk_state_t state_next;

    logic [DIV_W-1:0] div_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [RPM_W-1:0] dvd_reg;
    logic [RPM_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RPM_W-1:0] rpm_reg;
    logic             out_valid_reg;

    logic             out_free;
    logic             start_div;
    logic             load_zero;
    logic             load_quot;
    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] trial;
    logic             fits;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ppt_pkg::BK_IDLE: begin
                if (q_valid && q_job.in_range) begin
                    state_next = ppt_pkg::BK_DIVIDE;
                end
            end
            ppt_pkg::BK_DIVIDE: begin
                if (cnt_reg == LAST_STEP) begin
                    state_next = ppt_pkg::BK_PUBLISH;
                end
            end
            ppt_pkg::BK_PUBLISH: begin
                if (out_free) begin
                    state_next = ppt_pkg::BK_IDLE;
                end
            end
            default: state_next = ppt_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        start_div = 1'b0;
        load_zero = 1'b0;
        load_quot = 1'b0;
        unique case (state_reg)
            ppt_pkg::BK_IDLE: begin
                start_div = q_valid && q_job.in_range;
                load_zero = q_valid && !q_job.in_range && out_free;
            end
            ppt_pkg::BK_DIVIDE: begin
            end
            ppt_pkg::BK_PUBLISH: begin
                load_quot = out_free;
            end
            default: begin
            end
        endcase
    end

    assign q_pop = start_div || load_zero;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign shifted = {rem_reg, dvd_reg[RPM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = !trial[DIV_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ppt_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_zero || load_quot) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_div) begin
            div_reg  <= {1'b0, q_job.period} + DIV_W'(1);
            rem_reg  <= '0;
            dvd_reg  <= ppt_pkg::RPM_NUMERATOR;
            quot_reg <= '0;
            cnt_reg  <= '0;
        end else if (state_reg == ppt_pkg::BK_DIVIDE) begin
            rem_reg  <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            dvd_reg  <= {dvd_reg[RPM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[RPM_W-2:0], fits};
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (load_zero) begin
            rpm_reg <= '0;
        end else if (load_quot) begin
            rpm_reg <= quot_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ppt_pkg::M_TDATA_W - RPM_W){1'b0}}, rpm_reg};

    `PPT_ASSERT_IMP(a_bk_step_range, aclk, aresetn,
        state_reg == ppt_pkg::BK_DIVIDE, cnt_reg <= LAST_STEP)
    `PPT_ASSERT_IMP(a_bk_divisor_nonzero, aclk, aresetn,
        state_reg == ppt_pkg::BK_DIVIDE, div_reg != '0)
    `PPT_ASSERT_NEXT(a_bk_start_divides, aclk, aresetn,
        start_div, state_reg == ppt_pkg::BK_DIVIDE)

endmodule

### verif/ppt_speed_checker.sv
// Checker that predicts the tachometer speed results and compares them with the outputs.
module ppt_speed_checker
    import ppt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] timestamp_us
    input  logic [0:0]            s_tuser,   // [0] operation
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [25:0] rpm, [31:26] zero
    output int unsigned           fail_count,
    output int unsigned           rpm_pending
);

    logic [GLITCH_W-1:0] glitch_lim;
    logic [PERIOD_W-1:0] min_lim;
    logic [PERIOD_W-1:0] max_lim;
    logic [TS_W-1:0]     last_edge_ts;
    logic [TS_W-1:0]     period_us;
    logic [RPM_W-1:0]    rpm_expected_q[$];

    // Speed for a stored period under the current limits.
    function automatic logic [RPM_W-1:0] speed_for_period(input logic [TS_W-1:0] period);
        logic [TS_W:0] divisor;
        if (period < min_lim || period > max_lim) return '0;
        divisor = {1'b0, period} + 1'b1;
        return RPM_W'(RPM_NUMERATOR / divisor);
    endfunction

    always @(posedge aclk) begin : watch
        logic [TS_W-1:0]  gap;
        logic [RPM_W-1:0] want;
        if (!aresetn) begin
            glitch_lim   = GLITCH_RESET;
            min_lim      = MIN_PERIOD_RESET;
            max_lim      = MAX_PERIOD_RESET;
            last_edge_ts = '0;
            period_us    = '0;
            rpm_expected_q.delete();
            fail_count  <= 0;
            rpm_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_GLITCH:     glitch_lim = cfg_wdata[GLITCH_W-1:0];
                    CFG_MIN_PERIOD: min_lim = cfg_wdata;
                    CFG_MAX_PERIOD: max_lim = cfg_wdata;
                    default: ;
                endcase
            end
            // A result can never stem from an item taken at the same edge, so
            // the output side is settled before the input side.
            if (m_tvalid && m_tready) begin
                if (rpm_expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual rpm %0d",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = rpm_expected_q.pop_front();
                    if (m_tdata !== M_TDATA_W'(want)) begin
                        $display("%0t: rpm mismatch: expected %0d, actual %0d",
                                 $time, want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_EDGE) begin
                    gap          = s_tdata - last_edge_ts;
                    period_us    = (gap < glitch_lim) ? '0 : gap;
                    last_edge_ts = s_tdata;
                end else begin
                    rpm_expected_q.push_back(speed_for_period(period_us));
                end
            end
            rpm_pending <= rpm_expected_q.size();
        end
    end

endmodule

### verif/pulse_period_tachometer_unit_tb.sv
// Testbench top for the pulse period tachometer: stimulus, result sink and verdict.
module pulse_period_tachometer_unit_tb;
    import ppt_pkg::*;

    // Index that lies beyond the three registers; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Settling time once nothing more is expected, long enough for a report in
    // range to pass through the divider.
    localparam int DRAIN_CYCLES     = 40;
    // Length of the deliberate receiver hold-off that fills the job queue.
    localparam int SINK_HOLD_CYCLES = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GLITCH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;     // [31:0] timestamp_us
    logic [0:0]            s_tuser = OP_EDGE; // [0] operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [25:0] rpm, [31:26] zero

    int unsigned fail_count;
    int unsigned rpm_pending;

    // Stimulus bookkeeping: the time of the last edge sent and the limits
    // currently programmed, used only to aim edge gaps at interesting values.
    int unsigned           burst_left = 0;
    logic [TS_W-1:0]       edge_ts = '0;
    logic [GLITCH_W-1:0]   glitch_sh = GLITCH_RESET;
    logic [PERIOD_W-1:0]   min_sh = MIN_PERIOD_RESET;
    logic [PERIOD_W-1:0]   max_sh = MAX_PERIOD_RESET;

    // Receiver pattern state.
    int unsigned sink_run = 0;
    int unsigned hold_left = 0;
    logic        sink_hold_req = 1'b0;

    pulse_period_tachometer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ppt_speed_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .rpm_pending (rpm_pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard limit on the run. The slowest correct run is far below this: every
    // item a report in range, long sender gaps, receiver stalls and the long
    // hold-off together come to well under a tenth of it.
    initial begin
        #2_000_000;
        $display("pulse_period_tachometer_unit verification failed");
        $finish;
    end

    // Result sink. It mostly alternates short stalls with short ready runs, now
    // and then stays ready for a long stretch, and on request holds off for a
    // long fixed time so that the job queue fills and the input is stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_run  <= 0;
            hold_left <= 0;
        end else if (sink_hold_req) begin
            m_tready  <= 1'b0;
            hold_left <= SINK_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (sink_run != 0) begin
            sink_run <= sink_run - 1;
        end else begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    m_tready <= 1'b0;
                    sink_run <= $urandom_range(0, 5);
                end
                2: begin
                    m_tready <= 1'b1;
                    sink_run <= $urandom_range(30, 90);
                end
                default: begin
                    m_tready <= 1'b1;
                    sink_run <= $urandom_range(0, 4);
                end
            endcase
        end
    end

    // Offers one item and returns at the edge where it is taken. Items go out
    // in bursts of random length; between bursts the valid line drops for a
    // random number of cycles, sometimes none at all.
    task automatic send_item(input logic op, input logic [TS_W-1:0] ts);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 9);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ts;
        do @(posedge aclk); while (!s_tready);
    endtask

    // An edge a given number of microseconds after the previous one; the
    // timestamp wraps naturally at 32 bits.
    task automatic send_edge(input logic [TS_W-1:0] gap);
        edge_ts = edge_ts + gap;
        send_item(OP_EDGE, edge_ts);
    endtask

    // A report carries a random timestamp, which the block must ignore.
    task automatic send_report();
        send_item(OP_REPORT, $urandom());
    endtask

    // Stops offering items and waits until every expected result has come,
    // then gives the block time to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rpm_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Programs all three limits once the block has gone idle.
    task automatic set_limits(input logic [CFG_DATA_W-1:0] glitch,
                              input logic [CFG_DATA_W-1:0] min_p,
                              input logic [CFG_DATA_W-1:0] max_p);
        wait_idle();
        cfg_write(CFG_GLITCH, glitch);
        cfg_write(CFG_MIN_PERIOD, min_p);
        cfg_write(CFG_MAX_PERIOD, max_p);
        glitch_sh = glitch[GLITCH_W-1:0];
        min_sh    = min_p;
        max_sh    = max_p;
    endtask

    // Chooses an edge gap: most often inside the speed window, otherwise on the
    // boundaries of the glitch limit and the window, beyond it, or anywhere.
    function automatic logic [TS_W-1:0] pick_gap();
        logic [TS_W-1:0] lo;
        logic [TS_W-1:0] hi;
        logic [TS_W-1:0] g;
        lo = TS_W'(min_sh);
        hi = TS_W'(max_sh);
        case ($urandom_range(0, 9))
            0: g = $urandom_range(0, glitch_sh);
            1: g = lo + $urandom_range(0, 2) - 1;
            2: g = hi + $urandom_range(0, 2) - 1;
            3: g = hi + $urandom_range(1, 200000);
            4: g = $urandom();
            5: g = glitch_sh + $urandom_range(0, 2) - 1;
            default: g = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(hi, lo);
        endcase
        return g;
    endfunction

    // Random traffic. Most of it is a few edges followed by one or two
    // reports; the rest is reports with no fresh edge and items of any kind
    // with a timestamp anywhere in the 32-bit range.
    task automatic run_random(input int unsigned count);
        int unsigned sent;
        int unsigned kind;
        int unsigned edges;
        logic        op;
        logic [TS_W-1:0] ts;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                op = 1'($urandom_range(0, 1));
                ts = $urandom();
                if (op == OP_EDGE) edge_ts = ts;
                send_item(op, ts);
                sent++;
            end else begin
                edges = (kind == 1) ? 0 : $urandom_range(1, 3);
                repeat (edges) begin
                    send_edge(pick_gap());
                    sent++;
                end
                repeat ($urandom_range(1, 2)) begin
                    send_report();
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset limits (glitch 500, window 1000 to
        // 100000). Nothing has been measured yet, so the first report is zero
        // whatever timestamp it carries.
        send_item(OP_REPORT, '1);
        send_edge(3000);        // first edge is measured from time zero
        send_report();
        send_edge(100);         // a glitch clears the period
        send_report();
        send_edge(1000);        // lower end of the window
        send_report();
        send_edge(100000);      // upper end of the window
        send_report();
        send_edge(100001);      // just beyond the window
        send_report();
        send_edge(999);         // just below the window but not a glitch
        send_report();
        edge_ts = '1;           // all-ones timestamp, a huge gap
        send_item(OP_EDGE, edge_ts);
        send_report();
        send_edge(4352);        // gap across the 32-bit wrap
        send_report();
        send_edge(499);         // one short of the glitch limit
        send_edge(500);         // exactly the glitch limit
        send_report();
        edge_ts = '0;
        send_item(OP_EDGE, edge_ts);
        send_report();
        run_random(130);

        // Widest window and no glitch limit: a repeated timestamp gives a zero
        // period, which with a zero minimum yields the full numerator.
        set_limits('0, '0, '1);
        send_edge(0);
        send_report();
        send_edge(32'h000F_FFFF);
        send_report();
        run_random(130);

        // All ones written everywhere; the glitch register keeps its low 16
        // bits, and the window shrinks to the single largest period.
        set_limits('1, '1, '1);
        run_random(130);

        // Minimum above maximum: every report must come back as zero. A write
        // to the unused index must leave the limits alone.
        set_limits(20'd100, 20'd50000, 20'd40000);
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
        send_edge(45000);
        send_report();
        run_random(130);

        // Random limits. The receiver holds off for a long time while items
        // keep coming, so the job queue fills and the input is stalled.
        set_limits(CFG_DATA_W'($urandom_range(0, 65535)),
                   CFG_DATA_W'($urandom_range(0, 20000)),
                   CFG_DATA_W'($urandom_range(20000, 1000000)));
        sink_hold_req <= 1'b1;
        @(posedge aclk);
        sink_hold_req <= 1'b0;
        run_random(140);

        set_limits(20'd250, 20'd200, 20'd1000000);
        run_random(130);

        set_limits(CFG_DATA_W'(GLITCH_RESET), MIN_PERIOD_RESET, MAX_PERIOD_RESET);
        run_random(130);

        wait_idle();
        if (fail_count == 0) begin
            $display("pulse_period_tachometer_unit verification clean");
        end else begin
            $display("pulse_period_tachometer_unit verification failed");
        end
        $finish;
    end

endmodule
